// ----- hdl/i2c_bit_level_master_macros.svh -----
// Assertion macros shared by the bit-level I2C master RTL.
// Depends on nothing; the asserting module must have ports named clock and reset.
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CBM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2CBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/i2cbm_pkg.sv -----
// Shared types, command codes and widths of the bit-level I2C master.
// Depends on nothing; used by every module of the block.
package i2cbm_pkg;

   // Field widths.
   localparam int CMD_W      = 3;
   localparam int HALF_W     = 10;
   localparam int TIMEOUT_W  = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Default depth of the request queue between front and engine.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Reset values of the configuration registers.
   localparam logic [HALF_W-1:0]    HALF_PERIOD_RESET = 10'd10;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

   // Configuration register indexes.
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic [CMD_W-1:0] kind;
      logic [7:0]       tx_byte;
      logic             send_ack;
      logic             sda_in;
   } item_type;

   // Configuration seen by the engine.
   typedef struct packed {
      logic [HALF_W-1:0]    half_period;
      logic [TIMEOUT_W-1:0] ack_timeout;
   } cfg_type;

   // One result of the engine.
   typedef struct packed {
      logic       ack_error;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

endpackage

// ----- hdl/i2cbm_front.sv -----
// Front of the bit-level I2C master: accepts requests, classifies the command
// and queues them for the engine. Depends on i2cbm_pkg.
module i2cbm_front #(
   parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // Fields from bit 0: tx_byte[7:0], send_ack, sda_in, zero fill.
   input  logic [i2cbm_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: cmd[2:0].
   input  logic [i2cbm_pkg::CMD_W-1:0]      req_tuser,
   output logic                        q_valid,
   input  logic                        q_ready,
   output i2cbm_pkg::item_type         q_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   i2cbm_pkg::item_type entry_ff [QUEUE_DEPTH];
   i2cbm_pkg::item_type new_item;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   // Classify the command; codes without meaning become no command.
   always_comb begin
      new_item.tx_byte  = req_tdata[7:0];
      new_item.send_ack = req_tdata[8];
      new_item.sda_in   = req_tdata[9];
      unique case (req_tuser) inside
         i2cbm_pkg::CMD_START, i2cbm_pkg::CMD_STOP,
         i2cbm_pkg::CMD_WRITE, i2cbm_pkg::CMD_READ: begin
            new_item.kind = req_tuser;
         end
         default: begin
            new_item.kind = i2cbm_pkg::CMD_NONE;
         end
      endcase
   end

   // Queue control.
   assign req_tready = (count_ff != FULL_CNT);
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hdl/i2cbm_engine.sv -----
// Bus engine of the bit-level I2C master: runs one tick of the line sequencer
// per queued request and registers the result. Depends on i2cbm_pkg and the macros.
`include "i2c_bit_level_master_macros.svh"

module i2cbm_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  i2cbm_pkg::cfg_type           cfg,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  i2cbm_pkg::item_type          q_item,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output i2cbm_pkg::result_type        rsp_result
);

   // Sequencer phases.
   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_ST_A    = 5'd1;
   localparam logic [4:0] PH_ST_B    = 5'd2;
   localparam logic [4:0] PH_SP_A    = 5'd3;
   localparam logic [4:0] PH_SP_B    = 5'd4;
   localparam logic [4:0] PH_WB_A    = 5'd5;
   localparam logic [4:0] PH_WB_B    = 5'd6;
   localparam logic [4:0] PH_WB_C    = 5'd7;
   localparam logic [4:0] PH_WA_A    = 5'd8;
   localparam logic [4:0] PH_WA_B    = 5'd9;
   localparam logic [4:0] PH_WA_POLL = 5'd10;
   localparam logic [4:0] PH_RB_A    = 5'd11;
   localparam logic [4:0] PH_RB_B    = 5'd12;
   localparam logic [4:0] PH_RA_A    = 5'd13;
   localparam logic [4:0] PH_RA_B    = 5'd14;
   localparam logic [4:0] PH_FS_A    = 5'd15;
   localparam logic [4:0] PH_FS_B    = 5'd16;

   logic [4:0] phase_ff, phase_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_ff, shift_in;
   logic [i2cbm_pkg::HALF_W-1:0]    hold_ff, hold_in;
   logic [i2cbm_pkg::TIMEOUT_W-1:0] poll_ff, poll_in;
   logic answer_ack_ff, answer_ack_in;
   logic scl_ff, scl_in;
   logic sda_ff, sda_in;
   logic [7:0] rx_ff, rx_in;
   logic err_ff, err_in;
   logic done;
   logic fire;
   logic rsp_tvalid_in;
   logic [i2cbm_pkg::HALF_W-1:0] hold_load;
   i2cbm_pkg::result_type rsp_result_ff, result_in;

   // The output register takes a new result when empty or being drained.
   assign q_ready = !rsp_tvalid || rsp_tready;
   assign fire    = q_valid && q_ready;

   // Hold count loaded on each new line level; a zero half period acts as one.
   assign hold_load = (cfg.half_period == '0) ? '0 : cfg.half_period - 1'b1;

   // One tick of the sequencer.
   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      hold_in       = hold_ff;
      poll_in       = poll_ff;
      answer_ack_in = answer_ack_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      rx_in         = rx_ff;
      err_in        = err_ff;
      done          = 1'b0;
      if (phase_ff == PH_IDLE) begin
         // Start a new command.
         case (q_item.kind)
            i2cbm_pkg::CMD_START: begin
               phase_in = PH_ST_A; scl_in = 1'b1; sda_in = 1'b1; hold_in = hold_load;
            end
            i2cbm_pkg::CMD_STOP: begin
               phase_in = PH_SP_A; scl_in = 1'b0; sda_in = 1'b0; hold_in = hold_load;
            end
            i2cbm_pkg::CMD_WRITE: begin
               shift_in     = q_item.tx_byte;
               bit_index_in = '0;
               phase_in     = PH_WB_A;
               scl_in       = 1'b0;
               sda_in       = q_item.tx_byte[7];
               hold_in      = hold_load;
            end
            i2cbm_pkg::CMD_READ: begin
               shift_in      = '0;
               bit_index_in  = '0;
               answer_ack_in = q_item.send_ack;
               phase_in      = PH_RB_A;
               scl_in        = 1'b0;
               sda_in        = 1'b1;
               hold_in       = hold_load;
            end
            default: begin
            end
         endcase
      end else if (phase_ff == PH_WA_POLL) begin
         // Acknowledge poll with SCL high.
         if (!q_item.sda_in) begin
            scl_in   = 1'b0;
            err_in   = 1'b0;
            phase_in = PH_IDLE;
            done     = 1'b1;
         end else if (poll_ff >= cfg.ack_timeout) begin
            phase_in = PH_FS_A; scl_in = 1'b0; sda_in = 1'b0; hold_in = hold_load;
         end else begin
            poll_in = poll_ff + 1'b1;
         end
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - 1'b1;
      end else begin
         // Hold expired: make the next transition.
         unique case (phase_ff)
            PH_ST_A: begin
               phase_in = PH_ST_B; scl_in = 1'b1; sda_in = 1'b0; hold_in = hold_load;
            end
            PH_ST_B: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end
            PH_SP_A: begin
               phase_in = PH_SP_B; scl_in = 1'b1; sda_in = 1'b1; hold_in = hold_load;
            end
            PH_SP_B: begin
               phase_in = PH_IDLE; done = 1'b1;
            end
            PH_WB_A: begin
               phase_in = PH_WB_B; scl_in = 1'b1; hold_in = hold_load;
            end
            PH_WB_B: begin
               phase_in = PH_WB_C; scl_in = 1'b0; hold_in = hold_load;
            end
            PH_WB_C: begin
               if (bit_index_ff < 4'd7) begin
                  bit_index_in = bit_index_ff + 4'd1;
                  shift_in     = {shift_ff[6:0], 1'b0};
                  phase_in     = PH_WB_A;
                  scl_in       = 1'b0;
                  sda_in       = shift_ff[6];
               end else begin
                  phase_in = PH_WA_A;
                  scl_in   = 1'b0;
                  sda_in   = 1'b1;
               end
               hold_in = hold_load;
            end
            PH_WA_A: begin
               phase_in = PH_WA_B; scl_in = 1'b1; sda_in = 1'b1; hold_in = hold_load;
            end
            PH_WA_B: begin
               phase_in = PH_WA_POLL; poll_in = '0; hold_in = '0;
            end
            PH_RB_A: begin
               phase_in = PH_RB_B; scl_in = 1'b1; sda_in = 1'b1; hold_in = hold_load;
               shift_in = {shift_ff[6:0], q_item.sda_in};
            end
            PH_RB_B: begin
               if (bit_index_ff < 4'd7) begin
                  bit_index_in = bit_index_ff + 4'd1;
                  phase_in     = PH_RB_A;
                  sda_in       = 1'b1;
               end else begin
                  phase_in = PH_RA_A;
                  sda_in   = !answer_ack_ff;
               end
               scl_in  = 1'b0;
               hold_in = hold_load;
            end
            PH_RA_A: begin
               phase_in = PH_RA_B; scl_in = 1'b1; hold_in = hold_load;
            end
            PH_RA_B: begin
               scl_in = 1'b0; rx_in = shift_ff; phase_in = PH_IDLE; done = 1'b1;
            end
            PH_FS_A: begin
               phase_in = PH_FS_B; scl_in = 1'b1; sda_in = 1'b1; hold_in = hold_load;
            end
            PH_FS_B: begin
               err_in = 1'b1; phase_in = PH_IDLE; done = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Result of this tick, as seen after the update.
   always_comb begin
      result_in.scl_out   = scl_in;
      result_in.sda_out   = sda_in;
      result_in.busy_res  = (phase_in != PH_IDLE);
      result_in.done_res  = done;
      result_in.rx_byte   = rx_in;
      result_in.ack_error = err_in;
   end

   assign rsp_tvalid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid);

   // Sequencer state advances only when a request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         hold_ff       <= '0;
         poll_ff       <= '0;
         answer_ack_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rx_ff         <= '0;
         err_ff        <= 1'b0;
         rsp_tvalid    <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            bit_index_ff  <= bit_index_in;
            shift_ff      <= shift_in;
            hold_ff       <= hold_in;
            poll_ff       <= poll_in;
            answer_ack_ff <= answer_ack_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            rx_ff         <= rx_in;
            err_ff        <= err_in;
         end
         rsp_tvalid <= rsp_tvalid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_result = rsp_result_ff;

   // The sequencer never moves without a taken request.
   `I2CBM_ASSERT_NEXT(a_phase_holds, !fire, $stable(phase_ff), "phase moved without request")
   // During the acknowledge poll SCL is high and SDA released.
   `I2CBM_ASSERT_NOW(a_poll_lines, phase_ff == PH_WA_POLL, scl_ff && sda_ff, "bad poll lines")
   // An idle engine stays idle on no command.
   `I2CBM_ASSERT_NEXT(a_idle_none, fire && phase_ff == PH_IDLE && q_item.kind == i2cbm_pkg::CMD_NONE, phase_ff == PH_IDLE, "left idle on no command")
   // A completion is presented as a valid result that shows the engine idle.
   `I2CBM_ASSERT_NEXT(a_done_out, fire && done, rsp_tvalid && rsp_result.done_res && !rsp_result.busy_res, "completion lost")

endmodule

// ----- hdl/i2c_bit_level_master.sv -----
// Top level of the bit-level I2C master: configuration registers, request front
// and bus engine. Depends on i2cbm_pkg, i2cbm_front and i2cbm_engine.
//
// Every request is one tick of the bus engine and returns exactly one response
// with the SCL and SDA levels, busy and done flags, the last received byte and
// the acknowledge error flag as they stand after that tick. The block takes one
// request per clock cycle while the response side does not stall. A request is
// stored in the request queue, and its result is registered in the engine's
// output register after its sequencer step. The queue and the output register
// let either side stall without losing a request.
// The user must write the half period and acknowledge timeout through the csr
// port only while no request is in flight; the block itself does not enforce it.
module i2c_bit_level_master #(
   parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: tx_byte[7:0], send_ack, sda_in, zero fill.
   input  logic [i2cbm_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: cmd[2:0].
   input  logic [i2cbm_pkg::CMD_W-1:0]      req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: scl_out, sda_out, busy_res, done_res, rx_byte[7:0],
   // ack_error, zero fill.
   output logic [i2cbm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [i2cbm_pkg::HALF_W-1:0]     csr_wdata
);

   logic [i2cbm_pkg::HALF_W-1:0]    half_period_ff;
   logic [i2cbm_pkg::TIMEOUT_W-1:0] ack_timeout_ff;
   i2cbm_pkg::cfg_type    cfg;
   i2cbm_pkg::item_type   q_item;
   i2cbm_pkg::result_type rsp_result;
   logic q_valid, q_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cbm_pkg::HALF_PERIOD_RESET;
         ack_timeout_ff <= i2cbm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         if (csr_index == i2cbm_pkg::CSR_HALF_PERIOD) begin
            half_period_ff <= csr_wdata;
         end else if (csr_index == i2cbm_pkg::CSR_ACK_TIMEOUT) begin
            ack_timeout_ff <= csr_wdata[i2cbm_pkg::TIMEOUT_W-1:0];
         end
      end
   end

   assign cfg.half_period = half_period_ff;
   assign cfg.ack_timeout = ack_timeout_ff;

   // Request front and queue.
   i2cbm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   // Bus engine.
   i2cbm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Response packing.
   assign rsp_tdata = {3'b000, rsp_result};

endmodule

// ----- tb/i2cbm_tb_pkg.sv -----
`timescale 1ns / 100ps
// Bus-level tracker for the bit-level I2C master testbench: a tick-accurate
// predictor of the SCL/SDA engine and the queue of responses it expects.
// Depends on i2cbm_pkg for the command codes, the request and response types.
package i2cbm_tb_pkg;

   // Sequencer phases of the bus engine as the tracker sees them.
   typedef enum logic [4:0] {
      BUS_IDLE,
      START_SETUP, START_HOLD,
      STOP_SETUP, STOP_HOLD,
      WR_SETUP, WR_HIGH, WR_LOW,
      WACK_LOW, WACK_HIGH, WACK_POLL,
      RD_LOW, RD_HIGH,
      RACK_LOW, RACK_HIGH,
      ABORT_LOW, ABORT_HIGH
   } bus_phase_type;

   class bus_level_tracker;
      logic [i2cbm_pkg::HALF_W-1:0]    half_period;
      logic [i2cbm_pkg::TIMEOUT_W-1:0] ack_timeout;
      bus_phase_type                   phase;
      logic [3:0]                      bit_idx;
      logic [7:0]                      shreg;
      logic [i2cbm_pkg::HALF_W-1:0]    hold;
      logic [i2cbm_pkg::TIMEOUT_W-1:0] polls;
      logic                            answer_ack;
      logic                            scl;
      logic                            sda;
      logic [7:0]                      rx_held;
      logic                            err_held;
      i2cbm_pkg::result_type           pending_levels[$];
      int                              errors;
      int                              seen;

      function new();
         half_period = i2cbm_pkg::HALF_PERIOD_RESET;
         ack_timeout = i2cbm_pkg::ACK_TIMEOUT_RESET;
         phase       = BUS_IDLE;
         bit_idx     = '0;
         shreg       = '0;
         hold        = '0;
         polls       = '0;
         answer_ack  = 1'b0;
         scl         = 1'b1;
         sda         = 1'b1;
         rx_held     = '0;
         err_held    = 1'b0;
         errors      = 0;
         seen        = 0;
      endfunction

      function void set_cfg(logic idx, logic [i2cbm_pkg::HALF_W-1:0] value);
         if (idx == i2cbm_pkg::CSR_HALF_PERIOD) begin
            half_period = value;
         end else begin
            ack_timeout = value[i2cbm_pkg::TIMEOUT_W-1:0];
         end
      endfunction

      // Move to a new phase and hold its levels for one half period.
      // A half period of zero behaves like one.
      function void hold_level(bus_phase_type nxt, logic c, logic d);
         phase = nxt;
         scl   = c;
         sda   = d;
         hold  = (half_period == '0) ? '0 : half_period - 1'b1;
      endfunction

      // Transition taken when the current hold has run out.
      function bit advance();
         bit fin;
         fin = 1'b0;
         case (phase)
            START_SETUP: hold_level(START_HOLD, 1'b1, 1'b0);
            START_HOLD: begin
               scl   = 1'b0;
               phase = BUS_IDLE;
               fin   = 1'b1;
            end
            STOP_SETUP: hold_level(STOP_HOLD, 1'b1, 1'b1);
            STOP_HOLD: begin
               phase = BUS_IDLE;
               fin   = 1'b1;
            end
            WR_SETUP: hold_level(WR_HIGH, 1'b1, sda);
            WR_HIGH: hold_level(WR_LOW, 1'b0, sda);
            WR_LOW: begin
               if (bit_idx < 4'd7) begin
                  bit_idx++;
                  shreg = shreg << 1;
                  hold_level(WR_SETUP, 1'b0, shreg[7]);
               end else begin
                  hold_level(WACK_LOW, 1'b0, 1'b1);
               end
            end
            WACK_LOW: hold_level(WACK_HIGH, 1'b1, 1'b1);
            WACK_HIGH: begin
               phase = WACK_POLL;
               polls = '0;
               hold  = '0;
            end
            RD_LOW: hold_level(RD_HIGH, 1'b1, 1'b1);
            RD_HIGH: begin
               if (bit_idx < 4'd7) begin
                  bit_idx++;
                  hold_level(RD_LOW, 1'b0, 1'b1);
               end else begin
                  hold_level(RACK_LOW, 1'b0, !answer_ack);
               end
            end
            RACK_LOW: hold_level(RACK_HIGH, 1'b1, sda);
            RACK_HIGH: begin
               scl     = 1'b0;
               rx_held = shreg;
               phase   = BUS_IDLE;
               fin     = 1'b1;
            end
            ABORT_LOW: hold_level(ABORT_HIGH, 1'b1, 1'b1);
            ABORT_HIGH: begin
               err_held = 1'b1;
               phase    = BUS_IDLE;
               fin      = 1'b1;
            end
            default: phase = BUS_IDLE;
         endcase
         return fin;
      endfunction

      // One engine tick: the line levels and flags after this request.
      function i2cbm_pkg::result_type step(i2cbm_pkg::item_type it);
         i2cbm_pkg::result_type r;
         bit                    fin;
         fin = 1'b0;
         if (phase == BUS_IDLE) begin
            // Only the four known commands leave idle.
            case (it.kind)
               i2cbm_pkg::CMD_START: hold_level(START_SETUP, 1'b1, 1'b1);
               i2cbm_pkg::CMD_STOP: hold_level(STOP_SETUP, 1'b0, 1'b0);
               i2cbm_pkg::CMD_WRITE: begin
                  shreg   = it.tx_byte;
                  bit_idx = '0;
                  hold_level(WR_SETUP, 1'b0, it.tx_byte[7]);
               end
               i2cbm_pkg::CMD_READ: begin
                  shreg      = '0;
                  bit_idx    = '0;
                  answer_ack = it.send_ack;
                  hold_level(RD_LOW, 1'b0, 1'b1);
               end
               default: ;
            endcase
         end else if (phase == WACK_POLL) begin
            // Acknowledge poll: low ends the write, too many highs abort it.
            if (!it.sda_in) begin
               scl      = 1'b0;
               err_held = 1'b0;
               phase    = BUS_IDLE;
               fin      = 1'b1;
            end else if (polls >= ack_timeout) begin
               hold_level(ABORT_LOW, 1'b0, 1'b0);
            end else begin
               polls++;
            end
         end else if (hold != '0) begin
            hold--;
         end else begin
            fin = advance();
            // A read bit is sampled as SCL rises.
            if (phase == RD_HIGH) begin
               shreg = {shreg[6:0], it.sda_in};
            end
         end
         r.scl_out   = scl;
         r.sda_out   = sda;
         r.busy_res  = (phase != BUS_IDLE);
         r.done_res  = fin;
         r.rx_byte   = rx_held;
         r.ack_error = err_held;
         return r;
      endfunction

      function void take_request(i2cbm_pkg::item_type it);
         pending_levels.push_back(step(it));
      endfunction

      function int outstanding();
         return pending_levels.size();
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at response %0d: %s", seen, what);
      endtask

      // Compare one accepted response with the oldest expected one.
      task match_response(logic [i2cbm_pkg::RSP_DATA_W-1:0] raw);
         i2cbm_pkg::result_type got;
         i2cbm_pkg::result_type want;
         got = i2cbm_pkg::result_type'(raw[$bits(i2cbm_pkg::result_type)-1:0]);
         seen++;
         if (pending_levels.size() == 0) begin
            report($sformatf("response %h with nothing expected", raw));
            return;
         end
         want = pending_levels.pop_front();
         if (raw[i2cbm_pkg::RSP_DATA_W-1:$bits(i2cbm_pkg::result_type)] != '0) begin
            report($sformatf("nonzero fill bits in %h", raw));
         end
         if (got.scl_out !== want.scl_out) begin
            report($sformatf("scl_out got %b want %b", got.scl_out, want.scl_out));
         end
         if (got.sda_out !== want.sda_out) begin
            report($sformatf("sda_out got %b want %b", got.sda_out, want.sda_out));
         end
         if (got.busy_res !== want.busy_res) begin
            report($sformatf("busy_res got %b want %b", got.busy_res, want.busy_res));
         end
         if (got.done_res !== want.done_res) begin
            report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
         end
         if (got.rx_byte !== want.rx_byte) begin
            report($sformatf("rx_byte got %h want %h", got.rx_byte, want.rx_byte));
         end
         if (got.ack_error !== want.ack_error) begin
            report($sformatf("ack_error got %b want %b", got.ack_error, want.ack_error));
         end
      endtask

      // Anything still expected after the drain time is a missing response.
      task flush_leftovers();
         foreach (pending_levels[i]) begin
            report("expected response never arrived");
         end
         pending_levels.delete();
      endtask
   endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the bit-level I2C master testbench: clock, reset, request driver,
// response monitor and the test sequence. Depends on i2cbm_pkg, i2cbm_tb_pkg
// and the i2c_bit_level_master RTL.
module tb_top;

   // Widths taken from the design package.
   localparam int CMD_W      = i2cbm_pkg::CMD_W;
   localparam int HALF_W     = i2cbm_pkg::HALF_W;
   localparam int TIMEOUT_W  = i2cbm_pkg::TIMEOUT_W;
   localparam int REQ_DATA_W = i2cbm_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = i2cbm_pkg::RSP_DATA_W;

   // Command codes that carry no meaning and must be ignored.
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   // How the driver sets sda_in outside the acknowledge poll.
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   // Stall patterns of the response side.
   localparam int STALL_NONE     = 0;
   localparam int STALL_RANDOM   = 1;
   localparam int STALL_PERIODIC = 2;
   localparam int STALL_HEAVY    = 3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = i2cbm_pkg::CMD_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = i2cbm_pkg::CSR_HALF_PERIOD;
   logic [HALF_W-1:0]     csr_wdata  = '0;

   i2cbm_tb_pkg::bus_level_tracker tracker = new();
   int burst_left    = 0;
   int request_count = 0;
   int stall_cycle   = 0;

   i2c_bit_level_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The response side steps through its four stall patterns in turn.
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle / 97) % 4)
         STALL_NONE: rsp_tready <= 1'b1;
         STALL_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_tready <= (stall_cycle % 4) != 0;
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= 1'b1;
      endcase
   end

   // Check every accepted response.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.match_response(rsp_tdata);
      end
   end

   function automatic logic pick_sda(int mode);
      case (mode)
         SDA_LOW: return 1'b0;
         SDA_HIGH: return 1'b1;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Send one request; called and returning at a falling edge. The sender
   // works in bursts with random gaps between them.
   task automatic send_tick(logic [CMD_W-1:0] kind, logic [7:0] txb, logic sack, logic sda);
      i2cbm_pkg::item_type it;
      it.kind     = kind;
      it.tx_byte  = txb;
      it.send_ack = sack;
      it.sda_in   = sda;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {{(REQ_DATA_W - 10){1'b0}}, it.sda_in, it.send_ack, it.tx_byte};
      do @(posedge clock); while (!req_tready);
      tracker.take_request(it);
      request_count++;
      burst_left--;
      @(negedge clock);
   endtask

   // Issue a command and keep ticking until the engine is idle again. While
   // busy, the command field carries random noise that must be ignored. The
   // poll sees ack_after high samples before SDA goes low.
   task automatic run_command(logic [CMD_W-1:0] kind, logic [7:0] txb, logic sack,
                              int sda_mode, int ack_after);
      int   highs;
      logic sda;
      highs = 0;
      send_tick(kind, txb, sack, pick_sda(sda_mode));
      while (tracker.phase != i2cbm_tb_pkg::BUS_IDLE) begin
         if (tracker.phase == i2cbm_tb_pkg::WACK_POLL) begin
            sda = (highs < ack_after);
            highs++;
         end else begin
            sda = pick_sda(sda_mode);
         end
         send_tick(CMD_W'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                   sda);
      end
   endtask

   // Wait until every expected response has arrived, plus the pipeline depth.
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.outstanding() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (6) @(negedge clock);
      tracker.flush_leftovers();
   endtask

   // Write both registers while nothing is in flight.
   task automatic configure(logic [HALF_W-1:0] hp, logic [TIMEOUT_W-1:0] to);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= i2cbm_pkg::CSR_HALF_PERIOD;
      csr_wdata <= hp;
      tracker.set_cfg(i2cbm_pkg::CSR_HALF_PERIOD, hp);
      @(negedge clock);
      csr_index <= i2cbm_pkg::CSR_ACK_TIMEOUT;
      csr_wdata <= HALF_W'(to);
      tracker.set_cfg(i2cbm_pkg::CSR_ACK_TIMEOUT, HALF_W'(to));
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed commands with random content; the acknowledge poll
   // ends early, on the last allowed sample, or one sample too late.
   task automatic random_phase(int n);
      int stop_at;
      int pick;
      int to;
      int roll;
      int ack_after;
      stop_at = request_count + n;
      while (request_count < stop_at) begin
         pick = $urandom_range(0, 99);
         roll = $urandom_range(0, 99);
         to   = tracker.ack_timeout;
         if (roll < 70) begin
            ack_after = $urandom_range(0, (to < 4) ? to : 4);
         end else if (roll < 85) begin
            ack_after = to;
         end else begin
            ack_after = to + 1;
         end
         if (pick < 40) begin
            run_command(i2cbm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, ack_after);
         end else if (pick < 70) begin
            run_command(i2cbm_pkg::CMD_READ, 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, 0);
         end else if (pick < 80) begin
            run_command(i2cbm_pkg::CMD_START, 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, 0);
         end else if (pick < 90) begin
            run_command(i2cbm_pkg::CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, 0);
         end else if (pick < 95) begin
            run_command(i2cbm_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, 0);
         end else begin
            run_command(CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), 8'($urandom),
                        1'($urandom_range(0, 1)), SDA_RANDOM, 0);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: start and stop at the default half period.
      run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
      run_command(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

      // Short timing: byte extremes, ack on the first and last allowed poll,
      // an ack timeout, reads of all ones with ACK and all zeros with NACK.
      configure(10'd1, 8'd3);
      run_command(i2cbm_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 0);
      run_command(i2cbm_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM, 3);
      run_command(i2cbm_pkg::CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 4);
      run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0);
      run_command(i2cbm_pkg::CMD_READ, 8'hFF, 1'b0, SDA_LOW, 0);
      run_command(i2cbm_pkg::CMD_WRITE, 8'h5A, 1'b1, SDA_RANDOM, 0);
      run_command(i2cbm_pkg::CMD_NONE, 8'hFF, 1'b1, SDA_HIGH, 0);
      run_command(CMD_SPARE_A, 8'h00, 1'b0, SDA_LOW, 0);
      run_command(CMD_SPARE_B, 8'hFF, 1'b1, SDA_HIGH, 0);
      run_command(CMD_SPARE_C, 8'h00, 1'b0, SDA_LOW, 0);

      // Zero half period acts as one; zero timeout fails on the first high.
      configure(10'd0, 8'd0);
      run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
      run_command(i2cbm_pkg::CMD_WRITE, 8'h81, 1'b0, SDA_RANDOM, 0);
      run_command(i2cbm_pkg::CMD_WRITE, 8'h7E, 1'b0, SDA_RANDOM, 1);
      run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 0);
      run_command(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

      // Longest timeout, exceeded by one sample.
      configure(10'd1, 8'd255);
      run_command(i2cbm_pkg::CMD_WRITE, 8'h3C, 1'b0, SDA_RANDOM, 256);

      // Random traffic over several small settings.
      configure(10'd1, 8'd2);
      random_phase(40);
      configure(10'd2, 8'd6);
      random_phase(40);
      configure(10'd3, 8'd1);
      random_phase(40);
      configure(HALF_W'($urandom_range(1, 4)), TIMEOUT_W'($urandom_range(0, 8)));
      random_phase(40);

      wait_drained();
      if (tracker.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #(4_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/i2cbm_pkg.sv
hdl/i2cbm_front.sv
hdl/i2cbm_engine.sv
hdl/i2c_bit_level_master.sv
tb/i2cbm_tb_pkg.sv
tb/tb_top.sv
